/* sv/ptnp_pkg.sv */
// Shared types and constants of the prime test / next / previous block
`default_nettype none
package ptnp_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_TEST = 2'd0,
    OP_NEXT = 2'd1,
    OP_PREV = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_LOWER = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_WAIT3,
    ST_WAITA,
    ST_WAITB,
    ST_VERDICT,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

/* sv/ptnp_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module ptnp_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [ptnp_pkg::WIDTH-1:0]   dividend_i,
  input  wire  [ptnp_pkg::WIDTH-1:0]   divisor_i,
  output logic                         done_o,
  output ptnp_pkg::word_t              quotient_o,
  output ptnp_pkg::word_t              remainder_o
);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  ptnp_pkg::cnt_t          cnt_q, cnt_d;
  ptnp_pkg::word_t         rem_q, rem_d;
  ptnp_pkg::word_t         quo_q, quo_d;
  ptnp_pkg::word_t         dvs_q, dvs_d;
  logic [ptnp_pkg::WIDTH:0] trial;
  logic [ptnp_pkg::WIDTH:0] diff;

  assign trial = {rem_q, quo_q[ptnp_pkg::WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ptnp_pkg::cnt_t'(ptnp_pkg::WIDTH - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // borrow clear means the shifted remainder covers the divisor
      if (!diff[ptnp_pkg::WIDTH]) begin
        rem_d = diff[ptnp_pkg::WIDTH-1:0];
      end else begin
        rem_d = trial[ptnp_pkg::WIDTH-1:0];
      end
      quo_d = {quo_q[ptnp_pkg::WIDTH-2:0], ~diff[ptnp_pkg::WIDTH]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

/* sv/prime_test_next_previous.sv */
// Top level: prime test, next prime and previous prime by 6k+-1 trial division
//
//   channel   direction  handshake            payload
//   command   in         start / busy         op_i, number_i
//   result    out        done_o (one cycle)   is_prime_o, prime_value_o, status_o
//
// A transfer in happens at a clock edge with start high and busy low; busy
// stays high until the cycle after the result strobe.
// Every trial division runs through the one shared divider; when chained, a
// division is a load, then WIDTH quotient bits, and the done cycle loads the
// next divisor. Testing one candidate n passes the test and verdict states
// and makes up to 2 + 2*floor((isqrt(n)+1)/6) divisions: one by 3, the
// 6k-1/6k+1 pairs up to the root and the first 6k-1 past it; small and even
// candidates need none. Next and previous repeat that per candidate until a
// prime turns up.
// Reset (rst_ni low, asynchronous) returns the sequencer and divider to idle.
// The receiver cannot stall: the result is shown for exactly one cycle.
`default_nettype none
module prime_test_next_previous (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  output logic                        busy,
  input  wire  [1:0]                  op_i,
  input  wire  [ptnp_pkg::WIDTH-1:0]  number_i,
  output logic                        done_o,
  output logic                        is_prime_o,
  output ptnp_pkg::word_t             prime_value_o,
  output logic [1:0]                  status_o
);

  ptnp_pkg::state_e state_q, state_d;
  logic [1:0]       op_q, op_d;
  ptnp_pkg::word_t  cand_q, cand_d;     // candidate under test
  ptnp_pkg::word_t  d_q, d_d;           // current 6k-1 divisor
  logic             verdict_q, verdict_d;
  logic             is_prime_q, is_prime_d;
  ptnp_pkg::word_t  value_q, value_d;
  logic [1:0]       status_q, status_d;

  logic             div_start;
  ptnp_pkg::word_t  div_dvs;
  logic             div_done;
  ptnp_pkg::word_t  div_quo;
  ptnp_pkg::word_t  div_rem;

  // the one shared arithmetic unit
  ptnp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (cand_q),
    .divisor_i   (div_dvs),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptnp_pkg::ST_IDLE: begin
        if (start) begin
          case (op_i)
            ptnp_pkg::OP_TEST: state_d = ptnp_pkg::ST_TEST;
            ptnp_pkg::OP_NEXT: begin
              if (number_i < ptnp_pkg::word_t'(2) || number_i == '1) begin
                state_d = ptnp_pkg::ST_OUT;
              end else begin
                state_d = ptnp_pkg::ST_TEST;
              end
            end
            ptnp_pkg::OP_PREV: begin
              if (number_i < ptnp_pkg::word_t'(3)) begin
                state_d = ptnp_pkg::ST_OUT;
              end else begin
                state_d = ptnp_pkg::ST_TEST;
              end
            end
            default: state_d = ptnp_pkg::ST_OUT;
          endcase
        end
      end
      ptnp_pkg::ST_TEST: begin
        if (cand_q < ptnp_pkg::word_t'(4) || !cand_q[0]) begin
          state_d = ptnp_pkg::ST_VERDICT;
        end else begin
          state_d = ptnp_pkg::ST_WAIT3;
        end
      end
      ptnp_pkg::ST_WAIT3: begin
        if (div_done) begin
          state_d = (div_rem == '0) ? ptnp_pkg::ST_VERDICT : ptnp_pkg::ST_WAITA;
        end
      end
      ptnp_pkg::ST_WAITA: begin
        if (div_done) begin
          if (d_q > div_quo || div_rem == '0) begin
            state_d = ptnp_pkg::ST_VERDICT;
          end else begin
            state_d = ptnp_pkg::ST_WAITB;
          end
        end
      end
      ptnp_pkg::ST_WAITB: begin
        if (div_done) begin
          state_d = (div_rem == '0) ? ptnp_pkg::ST_VERDICT : ptnp_pkg::ST_WAITA;
        end
      end
      ptnp_pkg::ST_VERDICT: begin
        case (op_q)
          ptnp_pkg::OP_NEXT: begin
            if (verdict_q || cand_q == '1) begin
              state_d = ptnp_pkg::ST_OUT;
            end else begin
              state_d = ptnp_pkg::ST_TEST;
            end
          end
          ptnp_pkg::OP_PREV: begin
            state_d = verdict_q ? ptnp_pkg::ST_OUT : ptnp_pkg::ST_TEST;
          end
          default: state_d = ptnp_pkg::ST_OUT;
        endcase
      end
      ptnp_pkg::ST_OUT: state_d = ptnp_pkg::ST_IDLE;
      default: state_d = ptnp_pkg::ST_IDLE;
    endcase
  end

  // datapath updates and divider control
  always_comb begin
    op_d       = op_q;
    cand_d     = cand_q;
    d_d        = d_q;
    verdict_d  = verdict_q;
    is_prime_d = is_prime_q;
    value_d    = value_q;
    status_d   = status_q;
    div_start  = 1'b0;
    div_dvs    = d_q + ptnp_pkg::word_t'(2);
    case (state_q)
      ptnp_pkg::ST_IDLE: begin
        if (start) begin
          op_d       = op_i;
          is_prime_d = 1'b0;
          value_d    = '0;
          status_d   = ptnp_pkg::STATUS_OK;
          cand_d     = number_i;
          case (op_i)
            ptnp_pkg::OP_NEXT: begin
              if (number_i < ptnp_pkg::word_t'(2)) begin
                value_d = ptnp_pkg::word_t'(2);
              end else if (number_i == '1) begin
                status_d = ptnp_pkg::STATUS_OVERFLOW;
              end else begin
                cand_d = number_i + ptnp_pkg::word_t'(1);
              end
            end
            ptnp_pkg::OP_PREV: begin
              if (number_i < ptnp_pkg::word_t'(3)) begin
                status_d = ptnp_pkg::STATUS_NO_LOWER;
              end else begin
                cand_d = number_i - ptnp_pkg::word_t'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ptnp_pkg::ST_TEST: begin
        if (cand_q < ptnp_pkg::word_t'(4)) begin
          verdict_d = (cand_q >= ptnp_pkg::word_t'(2));
        end else if (!cand_q[0]) begin
          verdict_d = 1'b0;
        end else begin
          div_start = 1'b1;
          div_dvs   = ptnp_pkg::word_t'(3);
        end
      end
      ptnp_pkg::ST_WAIT3: begin
        if (div_done) begin
          if (div_rem == '0) begin
            verdict_d = 1'b0;
          end else begin
            d_d       = ptnp_pkg::word_t'(5);
            div_start = 1'b1;
            div_dvs   = ptnp_pkg::word_t'(5);
          end
        end
      end
      ptnp_pkg::ST_WAITA: begin
        if (div_done) begin
          // divisor past the square root once it exceeds n/d
          if (d_q > div_quo) begin
            verdict_d = 1'b1;
          end else if (div_rem == '0) begin
            verdict_d = 1'b0;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ptnp_pkg::ST_WAITB: begin
        if (div_done) begin
          if (div_rem == '0) begin
            verdict_d = 1'b0;
          end else begin
            d_d       = d_q + ptnp_pkg::word_t'(6);
            div_start = 1'b1;
            div_dvs   = d_q + ptnp_pkg::word_t'(6);
          end
        end
      end
      ptnp_pkg::ST_VERDICT: begin
        case (op_q)
          ptnp_pkg::OP_TEST: is_prime_d = verdict_q;
          ptnp_pkg::OP_NEXT: begin
            if (verdict_q) begin
              value_d = cand_q;
            end else if (cand_q == '1) begin
              status_d = ptnp_pkg::STATUS_OVERFLOW;
            end else begin
              cand_d = cand_q + ptnp_pkg::word_t'(1);
            end
          end
          ptnp_pkg::OP_PREV: begin
            // 2 is prime, so the downward walk always ends
            if (verdict_q) begin
              value_d = cand_q;
            end else begin
              cand_d = cand_q - ptnp_pkg::word_t'(1);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptnp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    cand_q     <= cand_d;
    d_q        <= d_d;
    verdict_q  <= verdict_d;
    is_prime_q <= is_prime_d;
    value_q    <= value_d;
    status_q   <= status_d;
  end

  assign busy          = (state_q != ptnp_pkg::ST_IDLE);
  assign done_o        = (state_q == ptnp_pkg::ST_OUT);
  assign is_prime_o    = is_prime_q;
  assign prime_value_o = value_q;
  assign status_o      = status_q;

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Testbench for prime_test_next_previous: directed table, random commands, predicted results
module testbench;

  // op code 3 is not in op_e; the block must answer with all fields zero
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int unsigned RANDOM_CMDS = 75;
  // no idling on the command side for this many commands at the tail of the run
  localparam int unsigned CALM_TAIL   = 20;
  // settle time after the last result before the verdict
  localparam int unsigned DRAIN_CYCLES = 40;
  // The slowest expected run stays well under the limit: the worst
  // directed command is next from 2^32-5, whose first odd successor has a
  // factor near 9241, and random search operands stay below 2^20.
  localparam int unsigned CYCLE_LIMIT = 10_000_000;

  // one result as seen on the result ports
  typedef struct packed {
    logic             is_prime;
    ptnp_pkg::word_t  prime_value;
    logic [1:0]       status;
  } answer_t;

  // one row of the directed table; typed_in rows carry their answer,
  // the rest are handed to the predictor
  typedef struct packed {
    logic [1:0]       op;
    ptnp_pkg::word_t  number;
    logic             typed_in;
    answer_t          answer;
  } cmd_row_t;

  logic             clk_i    = 1'b0;
  logic             rst_ni   = 1'b0;
  logic             start    = 1'b0;
  logic [1:0]       op_i     = ptnp_pkg::OP_TEST;
  ptnp_pkg::word_t  number_i = '0;
  logic             busy;
  logic             done_o;
  logic             is_prime_o;
  ptnp_pkg::word_t  prime_value_o;
  logic [1:0]       status_o;

  answer_t     answers_due [$];
  int unsigned faults = 0;
  int unsigned cycles = 0;

  // Directed part: small operands, the top of the range, divisors that hit
  // the square root exactly or the second member of a 6k-1/6k+1 pair, the
  // error codes of next and previous, and the reserved op.
  cmd_row_t directed_cmds [25] = '{
    '{ptnp_pkg::OP_TEST, 32'd0,         1'b1, '{1'b0, 32'd0, ptnp_pkg::STATUS_OK}},
    '{ptnp_pkg::OP_TEST, 32'd1,         1'b1, '{1'b0, 32'd0, ptnp_pkg::STATUS_OK}},
    '{ptnp_pkg::OP_TEST, 32'd2,         1'b1, '{1'b1, 32'd0, ptnp_pkg::STATUS_OK}},
    '{ptnp_pkg::OP_TEST, 32'd3,         1'b1, '{1'b1, 32'd0, ptnp_pkg::STATUS_OK}},
    '{ptnp_pkg::OP_TEST, 32'd4,         1'b0, '0},
    '{ptnp_pkg::OP_TEST, 32'd25,        1'b0, '0},
    '{ptnp_pkg::OP_TEST, 32'd35,        1'b0, '0},
    '{ptnp_pkg::OP_TEST, 32'd49,        1'b0, '0},
    '{ptnp_pkg::OP_TEST, 32'd65521,     1'b0, '0},
    '{ptnp_pkg::OP_TEST, 32'hFFFF_FFFF, 1'b0, '0},
    '{ptnp_pkg::OP_TEST, 32'hAAAA_AAAA, 1'b0, '0},
    '{ptnp_pkg::OP_TEST, 32'h5555_5555, 1'b0, '0},
    '{ptnp_pkg::OP_NEXT, 32'd0,         1'b1, '{1'b0, 32'd2, ptnp_pkg::STATUS_OK}},
    '{ptnp_pkg::OP_NEXT, 32'd1,         1'b1, '{1'b0, 32'd2, ptnp_pkg::STATUS_OK}},
    '{ptnp_pkg::OP_NEXT, 32'd2,         1'b0, '0},
    '{ptnp_pkg::OP_NEXT, 32'd65519,     1'b0, '0},
    '{ptnp_pkg::OP_NEXT, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd0, ptnp_pkg::STATUS_OVERFLOW}},
    '{ptnp_pkg::OP_NEXT, 32'hFFFF_FFFB, 1'b1, '{1'b0, 32'd0, ptnp_pkg::STATUS_OVERFLOW}},
    '{ptnp_pkg::OP_PREV, 32'd0,         1'b1, '{1'b0, 32'd0, ptnp_pkg::STATUS_NO_LOWER}},
    '{ptnp_pkg::OP_PREV, 32'd1,         1'b1, '{1'b0, 32'd0, ptnp_pkg::STATUS_NO_LOWER}},
    '{ptnp_pkg::OP_PREV, 32'd2,         1'b1, '{1'b0, 32'd0, ptnp_pkg::STATUS_NO_LOWER}},
    '{ptnp_pkg::OP_PREV, 32'd3,         1'b0, '0},
    '{ptnp_pkg::OP_PREV, 32'd65536,     1'b0, '0},
    '{OP_RESERVED,       32'd0,         1'b1, '{1'b0, 32'd0, ptnp_pkg::STATUS_OK}},
    '{OP_RESERVED,       32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd0, ptnp_pkg::STATUS_OK}}
  };

  prime_test_next_previous u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .number_i      (number_i),
    .done_o        (done_o),
    .is_prime_o    (is_prime_o),
    .prime_value_o (prime_value_o),
    .status_o      (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Trial division: 2, 3, then 6k-1 and 6k+1 while the divisor squared fits.
  function automatic bit divides_cleanly_never(input longint unsigned n);
    longint unsigned d;
    if (n <= 64'd3) return n >= 64'd2;
    if (n % 64'd2 == 64'd0 || n % 64'd3 == 64'd0) return 1'b0;
    for (d = 64'd5; d <= n / d; d += 64'd6) begin
      if (n % d == 64'd0 || n % (d + 64'd2) == 64'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Expected result of one command. Next searches upward and gives up once
  // the candidate no longer fits WIDTH bits; previous searches down to 2.
  function automatic answer_t prime_answer(input logic [1:0] op,
                                           input ptnp_pkg::word_t num);
    longint unsigned top;
    longint unsigned n;
    longint unsigned c;
    answer_t         a;
    top = ((64'd1 << (ptnp_pkg::WIDTH - 1)) << 1) - 64'd1;
    n   = 64'(num) & 64'hFFFF_FFFF & top;
    a   = '{1'b0, '0, ptnp_pkg::STATUS_OK};
    case (op)
      ptnp_pkg::OP_TEST: a.is_prime = divides_cleanly_never(n);
      ptnp_pkg::OP_NEXT: begin
        if (n <= 64'd1) begin
          a.prime_value = ptnp_pkg::word_t'(2);
        end else begin
          a.status = ptnp_pkg::STATUS_OVERFLOW;
          for (c = n + 64'd1; c > n && c <= top; c++) begin
            if (divides_cleanly_never(c)) begin
              a.prime_value = ptnp_pkg::word_t'(c & 64'hFFFF_FFFF);
              a.status      = ptnp_pkg::STATUS_OK;
              break;
            end
          end
        end
      end
      ptnp_pkg::OP_PREV: begin
        a.status = ptnp_pkg::STATUS_NO_LOWER;
        if (n > 64'd2) begin
          for (c = n - 64'd1; c >= 64'd2; c--) begin
            if (divides_cleanly_never(c)) begin
              a.prime_value = ptnp_pkg::word_t'(c & 64'hFFFF_FFFF);
              a.status      = ptnp_pkg::STATUS_OK;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Sometimes drop start for a burst of idle cycles before the next command.
  task automatic idle_burst(input bit allowed);
    if (allowed && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Present one command and hold it until the transfer (start high, busy low
  // at the edge). start stays high afterwards, so back-to-back commands go
  // through as soon as busy drops.
  task automatic issue_cmd(input logic [1:0] op, input ptnp_pkg::word_t num,
                           input answer_t due);
    start    <= 1'b1;
    op_i     <= op;
    number_i <= num;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    answers_due.push_back(due);
  endtask

  initial begin : stimulus
    int unsigned      bits;
    int unsigned      roll;
    logic [1:0]       op;
    ptnp_pkg::word_t  num;
    answer_t          due;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_cmds[i]) begin
      idle_burst(1'b1);
      due = directed_cmds[i].typed_in
            ? directed_cmds[i].answer
            : prime_answer(directed_cmds[i].op, directed_cmds[i].number);
      issue_cmd(directed_cmds[i].op, directed_cmds[i].number, due);
    end

    // Random part. Operands are mostly up to 16 bits, a few up to 20 bits, so
    // searches stay affordable. Full-width operands go only to test and are
    // forced to a multiple of three, which the block rejects early.
    for (int unsigned k = 0; k < RANDOM_CMDS; k++) begin
      roll = $urandom_range(0, 99);
      op   = (roll < 5) ? OP_RESERVED : 2'($urandom_range(0, 2));
      if (roll >= 92) begin
        op  = ptnp_pkg::OP_TEST;
        num = ptnp_pkg::word_t'($urandom());
        num = num - num % ptnp_pkg::word_t'(3);
      end else begin
        bits = (roll < 80) ? $urandom_range(2, 16) : $urandom_range(17, 20);
        num  = ptnp_pkg::word_t'($urandom())
               & ((ptnp_pkg::word_t'(1) << bits) - ptnp_pkg::word_t'(1));
      end
      idle_burst(k < RANDOM_CMDS - CALM_TAIL);
      issue_cmd(op, num, prime_answer(op, num));
    end
    start <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (faults == 0) begin
      $display("** prime_test_next_previous: PASSED **");
    end else begin
      $display("** prime_test_next_previous: FAILED **");
    end
    $finish;
  end

  // Result side: each strobe is matched against the oldest outstanding answer.
  always @(posedge clk_i) begin : result_check
    answer_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (answers_due.size() == 0) begin
        $error("result transfer with no command outstanding");
        faults++;
      end else begin
        want = answers_due.pop_front();
        if (is_prime_o !== want.is_prime) begin
          $error("is_prime: expected %0d, got %0d", want.is_prime, is_prime_o);
          faults++;
        end
        if (prime_value_o !== want.prime_value) begin
          $error("prime_value: expected %0d, got %0d", want.prime_value, prime_value_o);
          faults++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          faults++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** prime_test_next_previous: FAILED **");
      $finish;
    end
  end

endmodule
